// ----- rtl/wdmv_pkg.sv -----
`timescale 1ns / 1ps

package wdmv_pkg;

  localparam int unsigned Sectors = 8;
  localparam int unsigned SectorW = 3;
  localparam int unsigned AngleW  = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CodeW   = 8;

  localparam logic [CountW-1:0] WindowReset = 16'd100;

  typedef enum logic [SectorW-1:0] {
    SecN  = 3'd0,
    SecNE = 3'd1,
    SecE  = 3'd2,
    SecSE = 3'd3,
    SecS  = 3'd4,
    SecSW = 3'd5,
    SecW  = 3'd6,
    SecNW = 3'd7
  } sector_e;

  typedef struct packed {
    logic    hit;
    sector_e sector;
  } class_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] count;
  } result_t;

  function automatic logic [CodeW-1:0] sector_code(input sector_e s);
    logic [CodeW-1:0] c;
    case (s)
      SecN:    c = 8'h80;
      SecNE:   c = 8'h60;
      SecE:    c = 8'h40;
      SecSE:   c = 8'h20;
      SecS:    c = 8'hFF;
      SecSW:   c = 8'hDF;
      SecW:    c = 8'hBF;
      SecNW:   c = 8'h9F;
      default: c = 8'h80;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/wdmv_sample_if.sv -----
`timescale 1ns / 1ps

interface wdmv_sample_if;
  logic                         valid;
  logic                         ready;
  logic                         sample_valid;
  logic [wdmv_pkg::AngleW-1:0]  vane_angle;

  modport source (output valid, output sample_valid, output vane_angle, input ready);
  modport sink   (input valid, input sample_valid, input vane_angle, output ready);
endinterface

// ----- rtl/wdmv_result_if.sv -----
`timescale 1ns / 1ps

interface wdmv_result_if;
  logic                         valid;
  logic                         ready;
  logic [wdmv_pkg::CodeW-1:0]   direction_code;
  logic [wdmv_pkg::CountW-1:0]  winning_count;

  modport source (output valid, output direction_code, output winning_count, input ready);
  modport sink   (input valid, input direction_code, input winning_count, output ready);
endinterface

// ----- rtl/wdmv_cfg_if.sv -----
`timescale 1ns / 1ps

interface wdmv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wdmv_pkg::CountW-1:0]  window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ----- rtl/wdmv_sector.sv -----
`timescale 1ns / 1ps

module wdmv_sector (
  input  logic [wdmv_pkg::AngleW-1:0] angle_i,
  output wdmv_pkg::class_t            class_o
);

  always_comb begin
    class_o.hit    = 1'b1;
    class_o.sector = wdmv_pkg::SecN;
    case (angle_i[7:4])
      4'h7, 4'h8: class_o.sector = wdmv_pkg::SecN;
      4'h5, 4'h6: class_o.sector = wdmv_pkg::SecNE;
      4'h3, 4'h4: class_o.sector = wdmv_pkg::SecE;
      4'h1, 4'h2: class_o.sector = wdmv_pkg::SecSE;
      4'hF:       class_o.sector = wdmv_pkg::SecS;
      4'h0: begin
        class_o.sector = wdmv_pkg::SecS;
        class_o.hit    = (angle_i[3:0] != 4'h0);
      end
      4'hD, 4'hE: class_o.sector = wdmv_pkg::SecSW;
      4'hB, 4'hC: class_o.sector = wdmv_pkg::SecW;
      4'h9, 4'hA: class_o.sector = wdmv_pkg::SecNW;
      default:    class_o.sector = wdmv_pkg::SecN;
    endcase
  end

endmodule

// ----- rtl/wdmv_vote.sv -----
`timescale 1ns / 1ps

module wdmv_vote (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  wdmv_pkg::class_t             item_i,
  input  logic [wdmv_pkg::CountW-1:0]  window_size_i,
  input  logic                         out_ready_i,
  output logic                         stall_o,
  output logic                         res_valid_o,
  output wdmv_pkg::result_t            res_o
);

  localparam int unsigned N  = wdmv_pkg::Sectors;
  localparam int unsigned CW = wdmv_pkg::CountW;

  logic [CW-1:0]    cnt_q [N];
  logic [CW-1:0]    cnt_new [N];
  logic [CW-1:0]    sample_q, sample_d, sample_new;
  logic             take, emit, fire;
  logic             res_valid_q;
  wdmv_pkg::result_t res_q;

  logic [CW-1:0]                  l1_cnt [4];
  logic [wdmv_pkg::SectorW-1:0]   l1_idx [4];
  logic [CW-1:0]                  l2_cnt [2];
  logic [wdmv_pkg::SectorW-1:0]   l2_idx [2];
  logic [CW-1:0]                  best_cnt;
  logic [wdmv_pkg::SectorW-1:0]   best_idx;

  assign stall_o = res_valid_q && !out_ready_i;
  assign fire    = item_valid_i && !stall_o;
  assign take    = (sample_q < window_size_i);
  assign sample_new = take ? sample_q + 1'b1 : sample_q;
  assign emit    = !(sample_new < window_size_i);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      cnt_new[k] = cnt_q[k];
      if (take && item_i.hit && (item_i.sector == wdmv_pkg::sector_e'(k))) begin
        cnt_new[k] = cnt_q[k] + 1'b1;
      end
    end
  end

  // Lower index wins ties: take the right side only when strictly larger.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (cnt_new[2*k+1] > cnt_new[2*k]) begin
        l1_cnt[k] = cnt_new[2*k+1];
        l1_idx[k] = wdmv_pkg::SectorW'(2*k+1);
      end else begin
        l1_cnt[k] = cnt_new[2*k];
        l1_idx[k] = wdmv_pkg::SectorW'(2*k);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (l1_cnt[2*k+1] > l1_cnt[2*k]) begin
        l2_cnt[k] = l1_cnt[2*k+1];
        l2_idx[k] = l1_idx[2*k+1];
      end else begin
        l2_cnt[k] = l1_cnt[2*k];
        l2_idx[k] = l1_idx[2*k];
      end
    end
    if (l2_cnt[1] > l2_cnt[0]) begin
      best_cnt = l2_cnt[1];
      best_idx = l2_idx[1];
    end else begin
      best_cnt = l2_cnt[0];
      best_idx = l2_idx[0];
    end
  end

  always_comb begin
    sample_d = sample_q;
    if (fire) begin
      sample_d = emit ? '0 : sample_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      for (int k = 0; k < N; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      sample_q <= sample_d;
      if (fire) begin
        for (int k = 0; k < N; k++) begin
          cnt_q[k] <= emit ? '0 : cnt_new[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire && emit) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q.code  <= wdmv_pkg::sector_code(wdmv_pkg::sector_e'(best_idx));
      res_q.count <= best_cnt;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/wind_direction_majority_vote_top.sv -----
`timescale 1ns / 1ps

// Channel  | Role | Payload
// ---------+------+---------------------------------------
// sample_i | sink | sample_valid, vane_angle
// result_o | src  | direction_code, winning_count
// cfg_i    | sink | window_size (always ready)
//
// One sample per cycle while no held result stalls the input; a decision is made
// from the sample that closes the window, which passes the input register, then
// the counter update and the three-level compare tree into the result register.
// Reset clears all counters and loads window_size with 100.
// A held result stalls the vote stage; the input register still takes one more.
module wind_direction_majority_vote_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  wdmv_sample_if.sink    sample_i,
  wdmv_result_if.source  result_o,
  wdmv_cfg_if.sink       cfg_i
);

  logic                         stage_valid_q, stage_valid_d;
  wdmv_pkg::class_t             stage_q;
  wdmv_pkg::class_t             class_w;
  logic [wdmv_pkg::CountW-1:0]  window_q;
  logic                         stall;
  logic                         in_ready;
  logic                         res_valid;
  wdmv_pkg::result_t            res;

  wdmv_sector u_sector (
    .angle_i (sample_i.vane_angle),
    .class_o (class_w)
  );

  assign in_ready       = !stage_valid_q || !stall;
  assign sample_i.ready = in_ready;
  assign cfg_i.ready    = 1'b1;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_ready) begin
      stage_valid_d = sample_i.valid && sample_i.sample_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      window_q      <= wdmv_pkg::WindowReset;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (cfg_i.valid) begin
        window_q <= cfg_i.window_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      stage_q <= class_w;
    end
  end

  wdmv_vote u_vote (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (stage_valid_q),
    .item_i        (stage_q),
    .window_size_i (window_q),
    .out_ready_i   (result_o.ready),
    .stall_o       (stall),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign result_o.valid          = res_valid;
  assign result_o.direction_code = res.code;
  assign result_o.winning_count  = res.count;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                        sv;
    logic [wdmv_pkg::AngleW-1:0] angle;
  } vane_item_t;

  localparam logic [wdmv_pkg::CodeW-1:0] CompassCode [wdmv_pkg::Sectors] = '{
    8'h80, 8'h60, 8'h40, 8'h20, 8'hFF, 8'hDF, 8'hBF, 8'h9F
  };
  localparam logic [wdmv_pkg::AngleW-1:0] SectorLow [wdmv_pkg::Sectors] = '{
    8'h70, 8'h50, 8'h30, 8'h10, 8'hF0, 8'hD0, 8'hB0, 8'h90
  };
  localparam logic [wdmv_pkg::AngleW-1:0] BoundAngles [19] = '{
    8'h00, 8'h01, 8'h0F, 8'h10, 8'h2F, 8'h30, 8'h4F, 8'h50, 8'h6F, 8'h70,
    8'h8F, 8'h90, 8'hAF, 8'hB0, 8'hCF, 8'hD0, 8'hEF, 8'hF0, 8'hFF
  };

  logic clk_i;
  logic rst_ni;

  wdmv_sample_if smp ();
  wdmv_result_if res ();
  wdmv_cfg_if    cfg ();

  wind_direction_majority_vote_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  // vote tracking
  logic [wdmv_pkg::CountW-1:0] win_size;
  logic [wdmv_pkg::CountW-1:0] window_fill;
  logic [wdmv_pkg::CountW-1:0] sector_tally [wdmv_pkg::Sectors];
  wdmv_pkg::result_t           decision_q [$];

  vane_item_t        feed_q [$];
  bit                took_sample;
  bit                fast_feed;
  int                burst_left;
  int                gap_left;

  bit                long_hold_req;
  int                long_hold_left;
  int                rx_cycle;
  int                rx_mode;

  int                err_count;
  int                n_taken;
  int                n_noop;
  int                n_decisions;
  int                n_settings;

  function automatic wdmv_pkg::class_t sort_angle(logic [wdmv_pkg::AngleW-1:0] a);
    wdmv_pkg::class_t c;
    c.hit = 1'b1;
    c.sector = wdmv_pkg::SecN;
    if (a >= 8'h70 && a <= 8'h8F) c.sector = wdmv_pkg::SecN;
    else if (a >= 8'h50 && a <= 8'h6F) c.sector = wdmv_pkg::SecNE;
    else if (a >= 8'h30 && a <= 8'h4F) c.sector = wdmv_pkg::SecE;
    else if (a >= 8'h10 && a <= 8'h2F) c.sector = wdmv_pkg::SecSE;
    else if (a >= 8'hF0 || (a >= 8'h01 && a <= 8'h0F)) c.sector = wdmv_pkg::SecS;
    else if (a >= 8'hD0 && a <= 8'hEF) c.sector = wdmv_pkg::SecSW;
    else if (a >= 8'hB0 && a <= 8'hCF) c.sector = wdmv_pkg::SecW;
    else if (a >= 8'h90 && a <= 8'hAF) c.sector = wdmv_pkg::SecNW;
    else c.hit = 1'b0;
    return c;
  endfunction

  function automatic void vote_sample(logic sv, logic [wdmv_pkg::AngleW-1:0] a);
    wdmv_pkg::class_t  c;
    wdmv_pkg::result_t r;
    int                best;
    if (!sv) return;
    if (window_fill < win_size) begin
      c = sort_angle(a);
      if (c.hit) sector_tally[c.sector] = sector_tally[c.sector] + 1'b1;
      window_fill = window_fill + 1'b1;
    end
    if (window_fill >= win_size) begin
      best = 0;
      r.count = sector_tally[0];
      for (int k = 1; k < wdmv_pkg::Sectors; k++) begin
        if (sector_tally[k] > r.count) begin
          r.count = sector_tally[k];
          best = k;
        end
      end
      r.code = CompassCode[best];
      decision_q.push_back(r);
      window_fill = '0;
      for (int k = 0; k < wdmv_pkg::Sectors; k++) sector_tally[k] = '0;
    end
  endfunction

  function automatic logic [wdmv_pkg::AngleW-1:0] pick_angle(wdmv_pkg::sector_e lean);
    int unsigned off;
    case ($urandom_range(0, 9))
      0, 1: return BoundAngles[$urandom_range(0, 18)];
      2, 3, 4: return wdmv_pkg::AngleW'($urandom_range(0, 255));
      default: begin
        if (lean == wdmv_pkg::SecS) begin
          off = $urandom_range(0, 30);
          return (off >= 16) ? wdmv_pkg::AngleW'(off - 15) : wdmv_pkg::AngleW'(8'hF0 + off);
        end
        return wdmv_pkg::AngleW'(SectorLow[lean] + $urandom_range(0, 31));
      end
    endcase
  endfunction

  function automatic void queue_sample(logic sv, logic [wdmv_pkg::AngleW-1:0] a);
    vane_item_t it;
    it.sv = sv;
    it.angle = a;
    feed_q.push_back(it);
  endfunction

  task automatic settle();
    while (feed_q.size() != 0 || smp.valid) @(negedge clk_i);
    while (decision_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [wdmv_pkg::CountW-1:0] w);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.window_size <= w;
    do @(posedge clk_i); while (!cfg.ready);
    win_size = w;
    n_settings++;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    smp.valid = 1'b0;
    smp.sample_valid = 1'b0;
    smp.vane_angle = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.window_size = '0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // transfers on both channels, predict and compare
  always @(posedge clk_i) begin
    took_sample = 1'b0;
    if (rst_ni && smp.valid && smp.ready) begin
      took_sample = 1'b1;
      n_taken++;
      if (!smp.sample_valid) n_noop++;
      vote_sample(smp.sample_valid, smp.vane_angle);
      void'(feed_q.pop_front());
    end
    if (rst_ni && res.valid && res.ready) begin
      if (decision_q.size() == 0) begin
        $error("unexpected result: direction_code %h winning_count %0d",
               res.direction_code, res.winning_count);
        err_count++;
      end else begin
        wdmv_pkg::result_t want;
        want = decision_q.pop_front();
        n_decisions++;
        if (res.direction_code !== want.code) begin
          $error("direction_code mismatch: expected %h, actual %h",
                 want.code, res.direction_code);
          err_count++;
        end
        if (res.winning_count !== want.count) begin
          $error("winning_count mismatch: expected %0d, actual %0d",
                 want.count, res.winning_count);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : sample_driver
    logic go;
    go = 1'b0;
    if (!rst_ni) begin
      smp.valid <= 1'b0;
    end else if (!(smp.valid && !took_sample)) begin
      if (fast_feed) begin
        go = feed_q.size() > 0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (feed_q.size() > 0) begin
        go = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      smp.valid <= go;
      if (go) begin
        smp.sample_valid <= feed_q[0].sv;
        smp.vane_angle <= feed_q[0].angle;
      end
    end
  end

  always @(negedge clk_i) begin : result_sink
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (long_hold_req) begin
        long_hold_left = 400;
        long_hold_req = 1'b0;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = (rx_cycle % 5) != 0;
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
    res.ready <= rdy;
  end

  initial begin
    int                rand_valid;
    int                n;
    wdmv_pkg::sector_e lean;
    win_size = wdmv_pkg::WindowReset;
    window_fill = '0;
    for (int k = 0; k < wdmv_pkg::Sectors; k++) sector_tally[k] = '0;
    rand_valid = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window length
    repeat (230) queue_sample(1'b1, pick_angle(wdmv_pkg::SecE));
    settle();

    set_window(16'd0);
    queue_sample(1'b1, 8'h5A);
    queue_sample(1'b0, 8'h33);
    settle();

    set_window(16'd1);
    foreach (BoundAngles[i]) queue_sample(1'b1, BoundAngles[i]);
    settle();

    set_window(16'd4);
    queue_sample(1'b1, 8'h2F);
    queue_sample(1'b1, 8'h50);
    queue_sample(1'b1, 8'h10);
    queue_sample(1'b1, 8'h6F);
    settle();

    // fill the block while the receiver holds off
    set_window(16'd1);
    long_hold_req = 1'b1;
    repeat (60) queue_sample(1'b1, wdmv_pkg::AngleW'($urandom_range(0, 255)));
    settle();

    while (rand_valid < 1230) begin
      case ($urandom_range(0, 9))
        0: set_window(16'd1);
        1: set_window(16'd2);
        2, 3: set_window(wdmv_pkg::CountW'($urandom_range(3, 8)));
        8: set_window(wdmv_pkg::CountW'($urandom_range(41, 120)));
        default: set_window(wdmv_pkg::CountW'($urandom_range(9, 40)));
      endcase
      n = $urandom_range(40, 160);
      lean = wdmv_pkg::sector_e'($urandom_range(0, wdmv_pkg::Sectors - 1));
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_sample(1'b0, wdmv_pkg::AngleW'($urandom_range(0, 255)));
        end else begin
          queue_sample(1'b1, pick_angle(lean));
          rand_valid++;
        end
      end
      settle();
      // shrink the window to at most what it already holds
      if ($urandom_range(0, 2) == 0 && window_fill > 0) begin
        set_window(wdmv_pkg::CountW'($urandom_range(0, window_fill)));
        queue_sample(1'b1, wdmv_pkg::AngleW'($urandom_range(0, 255)));
        rand_valid++;
        settle();
      end
    end

    // largest window, then close it early by shrinking
    set_window(16'hFFFF);
    fast_feed = 1'b1;
    repeat (150) begin
      if ($urandom_range(0, 15) == 0) begin
        queue_sample(1'b0, wdmv_pkg::AngleW'($urandom_range(0, 255)));
      end
      queue_sample(1'b1, pick_angle(wdmv_pkg::SecSW));
    end
    settle();
    fast_feed = 1'b0;
    set_window(16'd100);
    queue_sample(1'b1, pick_angle(wdmv_pkg::SecSW));
    settle();

    set_window(16'd3);
    repeat (40) queue_sample(1'b1, pick_angle(wdmv_pkg::SecNW));
    settle();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d sample transfers (%0d no-op) over %0d window settings,",
             n_taken, n_noop, n_settings);
    $display("with %0d direction decisions checked and %0d errors.", n_decisions, err_count);
    if (err_count == 0 && decision_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
